// ----- rtl/stc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the THP compensation pipeline.
package stc_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned DIV_W     = 64;
    localparam int unsigned DIVR_W    = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_9 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_B   = 3'd5;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SENT = 2'd1;
    localparam logic [1:0] STAT_DIVZ = 2'd2;

    localparam logic [19:0] SENT_20   = 20'h80000;
    localparam logic [15:0] SENT_16   = 16'h8000;
    localparam logic [31:0] HUM_LIMIT = 32'd419430400;
    localparam logic [16:0] HUM_MAX   = 17'd102400;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [15:0] h4;
        logic [15:0] h5;
        logic [7:0]  h6;
    } t_coeffs;

    typedef struct packed {
        logic [26:0] temp;
        logic [16:0] hum;
        logic        sent;
        logic        divz;
    } t_side;

    typedef struct packed {
        logic [DIV_W-1:0]  an;
        logic [DIVR_W-1:0] ad;
        logic              neg;
        t_side             side;
    } t_div_in;

    typedef struct packed {
        logic [DIV_W-1:0] quo;
        logic             neg;
        t_side            side;
    } t_div_out;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        asr32 = $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        asr64 = $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] sx16_32(input logic [15:0] x);
        sx16_32 = {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx8_32(input logic [7:0] x);
        sx8_32 = {{24{x[7]}}, x};
    endfunction

    function automatic logic [63:0] sx16_64(input logic [15:0] x);
        sx16_64 = {{48{x[15]}}, x};
    endfunction

    // low 64 bits of a * b, b taken signed or unsigned
    function automatic logic [63:0] mul64x16(input logic [63:0] a, input logic [15:0] b,
                                             input logic b_signed);
        logic [79:0] pu;
        logic [63:0] corr;
        pu   = {16'd0, a} * {64'd0, b};
        corr = (b_signed && b[15]) ? {a[47:0], 16'd0} : 64'd0;
        mul64x16 = pu[63:0] - corr;
    endfunction

endpackage

// ----- rtl/sensor_thp_compensation.sv -----
// Top level of the temperature, pressure and humidity compensation pipeline.
// Throughput: one transaction per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset: synchronous active-low; clears all valid bits and the calibration registers.
module sensor_thp_compensation (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [19:0]                  i_raw_pressure,
    input  logic [19:0]                  i_raw_temperature,
    input  logic [15:0]                  i_raw_humidity,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [26:0]           o_temperature_centi_c,
    output logic [31:0]                  o_pressure_q24_8_pa,
    output logic [16:0]                  o_humidity_q22_10,
    output logic [1:0]                   o_status,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [stc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                  i_cfg_data
);

    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_a;
    logic [63:0] r_press_b;
    logic [15:0] r_press_9;
    logic [31:0] r_hum_a;
    logic [39:0] r_hum_b;

    stc_pkg::t_coeffs  w_coef;
    stc_pkg::t_div_in  w_div_in;
    stc_pkg::t_div_out w_div_out;
    logic              w_en, w_front_v, w_div_v, w_out_v;
    logic [26:0]       w_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_a     <= '0;
            r_press_b     <= '0;
            r_press_9     <= '0;
            r_hum_a       <= '0;
            r_hum_b       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                stc_pkg::CFG_TEMP:    r_temp_coeffs <= i_cfg_data[47:0];
                stc_pkg::CFG_PRESS_A: r_press_a     <= i_cfg_data;
                stc_pkg::CFG_PRESS_B: r_press_b     <= i_cfg_data;
                stc_pkg::CFG_PRESS_9: r_press_9     <= i_cfg_data[15:0];
                stc_pkg::CFG_HUM_A:   r_hum_a       <= i_cfg_data[31:0];
                stc_pkg::CFG_HUM_B:   r_hum_b       <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign w_coef.t1 = r_temp_coeffs[15:0];
    assign w_coef.t2 = r_temp_coeffs[31:16];
    assign w_coef.t3 = r_temp_coeffs[47:32];
    assign w_coef.p1 = r_press_a[15:0];
    assign w_coef.p2 = r_press_a[31:16];
    assign w_coef.p3 = r_press_a[47:32];
    assign w_coef.p4 = r_press_a[63:48];
    assign w_coef.p5 = r_press_b[15:0];
    assign w_coef.p6 = r_press_b[31:16];
    assign w_coef.p7 = r_press_b[47:32];
    assign w_coef.p8 = r_press_b[63:48];
    assign w_coef.p9 = r_press_9;
    assign w_coef.h1 = r_hum_a[7:0];
    assign w_coef.h2 = r_hum_a[23:8];
    assign w_coef.h3 = r_hum_a[31:24];
    assign w_coef.h4 = r_hum_b[15:0];
    assign w_coef.h5 = r_hum_b[31:16];
    assign w_coef.h6 = r_hum_b[39:32];

    assign w_en       = !w_out_v || i_out_ready;
    assign o_in_ready = w_en;

    stc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_valid           (i_in_valid),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_humidity    (i_raw_humidity),
        .i_coef            (w_coef),
        .o_valid           (w_front_v),
        .o_data            (w_div_in)
    );

    stc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_v),
        .i_data  (w_div_in),
        .o_valid (w_div_v),
        .o_data  (w_div_out)
    );

    stc_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_en                  (w_en),
        .i_valid               (w_div_v),
        .i_data                (w_div_out),
        .i_coef                (w_coef),
        .o_valid               (w_out_v),
        .o_temperature_centi_c (w_temp),
        .o_pressure_q24_8_pa   (o_pressure_q24_8_pa),
        .o_humidity_q22_10     (o_humidity_q22_10),
        .o_status              (o_status)
    );

    assign o_out_valid           = w_out_v;
    assign o_temperature_centi_c = $signed(w_temp);

`ifndef ASSERT_OFF
    a_sent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == stc_pkg::STAT_SENT |->
        o_temperature_centi_c == 27'sd0 && o_pressure_q24_8_pa == 32'd0 &&
        o_humidity_q22_10 == 17'd0)
        else $error("sentinel transaction with nonzero result");

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == stc_pkg::STAT_DIVZ |-> o_pressure_q24_8_pa == 32'd0)
        else $error("zero divisor transaction with nonzero pressure");

    a_stat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == stc_pkg::STAT_OK || o_status == stc_pkg::STAT_SENT ||
        o_status == stc_pkg::STAT_DIVZ)
        else $error("undefined status code");

    a_hum_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_humidity_q22_10 <= stc_pkg::HUM_MAX)
        else $error("humidity above clamp");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("pipeline stalled without a pending result");
`endif

endmodule

// ----- rtl/stc_front.sv -----
// Front pipeline: temperature, humidity and pressure terms up to the divider input.
module stc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [19:0]      i_raw_pressure,
    input  logic [19:0]      i_raw_temperature,
    input  logic [15:0]      i_raw_humidity,
    input  stc_pkg::t_coeffs i_coef,
    output logic             o_valid,
    output stc_pkg::t_div_in o_data
);

    logic [11:1] r_v;

    logic [31:0] r1_pa, r1_bb;
    logic [31:0] r2_v1, r2_pc;
    logic [31:0] r3_tf;
    logic [31:0] r4_m5, r4_m6, r4_m3;
    logic [63:0] r4_sq, r4_w1p5, r4_w1p2;
    logic [31:0] r5_ya;
    logic [63:0] r5_w2a, r5_w1a, r5_w1p5, r5_w1p2;
    logic [31:0] r6_yb;
    logic [63:0] r6_w2, r6_w1b;
    logic [31:0] r7_y;
    logic [63:0] r7_na, r7_w1c;
    logic [63:0] r8_num;
    logic [30:0] r8_d;
    logic [31:0] r9_ss;
    logic [31:0] r10_q;
    logic [16:0] r11_hum;

    logic        r_sent  [1:11];
    logic [19:0] r_adc_p [1:6];
    logic [15:0] r_adc_h [1:4];
    logic [26:0] r_temp  [4:11];
    logic [31:0] r_x     [5:7];
    logic [31:0] r_hx    [8:10];
    logic [63:0] r_an    [9:11];
    logic [30:0] r_ad    [9:11];
    logic        r_neg   [9:11];
    logic        r_divz  [9:11];

    logic [31:0]        n1_a, n1_b;
    logic               n1_sent;
    logic [31:0]        n2_bbs;
    logic [31:0]        n4_t5, n4_temp, n4_h;
    logic signed [32:0] n4_w1;
    logic signed [65:0] n4_sq66;
    logic signed [63:0] n4_w1p5, n4_w1p2;
    logic [31:0]        n5_xs, n5_x, n5_ya;
    logic [31:0]        n6_yb;
    logic [63:0]        n6_w2, n6_w1b;
    logic [31:0]        n7_y;
    logic [20:0]        n7_base;
    logic [63:0]        n7_na;
    logic [31:0]        n9_s;
    logic [31:0]        n11_hf;
    logic [16:0]        n11_hum;

    always_comb begin
        n1_a    = {15'd0, i_raw_temperature[19:3]} - {15'd0, i_coef.t1, 1'b0};
        n1_b    = {16'd0, i_raw_temperature[19:4]} - {16'd0, i_coef.t1};
        n1_sent = (i_raw_temperature == stc_pkg::SENT_20) ||
                  (i_raw_pressure == stc_pkg::SENT_20) ||
                  (i_raw_humidity == stc_pkg::SENT_16);
        n2_bbs  = stc_pkg::asr32(r1_bb, 12);
        n4_t5   = r3_tf * 32'd5 + 32'd128;
        n4_temp = stc_pkg::asr32(n4_t5, 8);
        n4_h    = r3_tf - 32'd76800;
        n4_w1   = $signed({r3_tf[31], r3_tf}) - 33'sd128000;
        n4_sq66 = n4_w1 * n4_w1;
        n4_w1p5 = n4_w1 * $signed(i_coef.p5);
        n4_w1p2 = n4_w1 * $signed(i_coef.p2);
        n5_xs   = {2'd0, r_adc_h[4], 14'd0} - {i_coef.h4[11:0], 20'd0} - r4_m5 + 32'd16384;
        n5_x    = stc_pkg::asr32(n5_xs, 15);
        n5_ya   = stc_pkg::asr32(r4_m6, 10) * (stc_pkg::asr32(r4_m3, 11) + 32'd32768);
        n6_yb   = (stc_pkg::asr32(r5_ya, 10) + 32'd2097152) * stc_pkg::sx16_32(i_coef.h2);
        n6_w2   = r5_w2a + (r5_w1p5 << 17) + (stc_pkg::sx16_64(i_coef.p4) << 35);
        n6_w1b  = stc_pkg::asr64(r5_w1a, 8) + (r5_w1p2 << 12);
        n7_y    = stc_pkg::asr32(r6_yb + 32'd8192, 14);
        n7_base = 21'd1048576 - {1'b0, r_adc_p[6]};
        n7_na   = {12'd0, n7_base, 31'd0} - r6_w2;
        n9_s    = stc_pkg::asr32(r8_num[31:0] ^ r8_num[31:0] ^ r_hx[8], 15);
        n11_hf  = r_hx[10] - stc_pkg::asr32(r10_q, 4);
        if (n11_hf[31]) begin
            n11_hum = 17'd0;
        end else if (n11_hf > stc_pkg::HUM_LIMIT) begin
            n11_hum = stc_pkg::HUM_MAX;
        end else begin
            n11_hum = n11_hf[28:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[10:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pa   <= n1_a * stc_pkg::sx16_32(i_coef.t2);
            r1_bb   <= n1_b * n1_b;
            r2_v1   <= stc_pkg::asr32(r1_pa, 11);
            r2_pc   <= n2_bbs * stc_pkg::sx16_32(i_coef.t3);
            r3_tf   <= r2_v1 + stc_pkg::asr32(r2_pc, 14);
            r4_m5   <= n4_h * stc_pkg::sx16_32(i_coef.h5);
            r4_m6   <= n4_h * stc_pkg::sx8_32(i_coef.h6);
            r4_m3   <= n4_h * {24'd0, i_coef.h3};
            r4_sq   <= n4_sq66[63:0];
            r4_w1p5 <= n4_w1p5;
            r4_w1p2 <= n4_w1p2;
            r5_ya   <= n5_ya;
            r5_w2a  <= stc_pkg::mul64x16(r4_sq, i_coef.p6, 1'b1);
            r5_w1a  <= stc_pkg::mul64x16(r4_sq, i_coef.p3, 1'b1);
            r5_w1p5 <= r4_w1p5;
            r5_w1p2 <= r4_w1p2;
            r6_yb   <= n6_yb;
            r6_w2   <= n6_w2;
            r6_w1b  <= n6_w1b;
            r7_y    <= n7_y;
            r7_na   <= n7_na;
            r7_w1c  <= stc_pkg::mul64x16(r6_w1b + 64'h0000_8000_0000_0000, i_coef.p1, 1'b0);
            r8_num  <= stc_pkg::mul64x16(r7_na, 16'd3125, 1'b0);
            r8_d    <= r7_w1c[63:33];
            r9_ss   <= n9_s * n9_s;
            r10_q   <= stc_pkg::asr32(r9_ss, 7) * {24'd0, i_coef.h1};
            r11_hum <= n11_hum;

            r_sent[1]  <= n1_sent;
            r_adc_p[1] <= i_raw_pressure;
            r_adc_h[1] <= i_raw_humidity;
            for (int k = 2; k <= 11; k++) begin
                r_sent[k] <= r_sent[k-1];
            end
            for (int k = 2; k <= 6; k++) begin
                r_adc_p[k] <= r_adc_p[k-1];
            end
            for (int k = 2; k <= 4; k++) begin
                r_adc_h[k] <= r_adc_h[k-1];
            end
            r_temp[4] <= n4_temp[26:0];
            for (int k = 5; k <= 11; k++) begin
                r_temp[k] <= r_temp[k-1];
            end
            r_x[5] <= n5_x;
            r_x[6] <= r_x[5];
            r_x[7] <= r_x[6];
            r_hx[8]  <= r_x[7] * r7_y;
            r_hx[9]  <= r_hx[8];
            r_hx[10] <= r_hx[9];
            r_an[9]   <= r8_num[63] ? 64'd0 - r8_num : r8_num;
            r_ad[9]   <= r8_d[30] ? 31'd0 - r8_d : r8_d;
            r_neg[9]  <= r8_num[63] ^ r8_d[30];
            r_divz[9] <= (r8_d == 31'd0);
            for (int k = 10; k <= 11; k++) begin
                r_an[k]   <= r_an[k-1];
                r_ad[k]   <= r_ad[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_divz[k] <= r_divz[k-1];
            end
        end
    end

    assign o_valid          = r_v[11];
    assign o_data.an        = r_an[11];
    assign o_data.ad        = r_ad[11];
    assign o_data.neg       = r_neg[11];
    assign o_data.side.temp = r_temp[11];
    assign o_data.side.hum  = r11_hum;
    assign o_data.side.sent = r_sent[11];
    assign o_data.side.divz = r_divz[11];

endmodule

// ----- rtl/stc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for the pressure quotient.
module stc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  stc_pkg::t_div_in  i_data,
    output logic              o_valid,
    output stc_pkg::t_div_out o_data
);

    localparam int unsigned W  = stc_pkg::DIV_W;
    localparam int unsigned RW = stc_pkg::DIVR_W;

    typedef struct packed {
        logic [RW-1:0]  rem;
        logic [W-1:0]   nq;
        logic [RW-1:0]  ad;
        logic           neg;
        stc_pkg::t_side side;
    } t_dstage;

    logic [W-1:0] r_v;
    t_dstage      r_st [W];
    t_dstage      n_st [W];
    t_dstage      src;
    logic [RW:0]  trial;
    logic         ge;

    always_comb begin
        for (int k = 0; k < W; k++) begin
            if (k == 0) begin
                src.rem  = '0;
                src.nq   = i_data.an;
                src.ad   = i_data.ad;
                src.neg  = i_data.neg;
                src.side = i_data.side;
            end else begin
                src = r_st[k-1];
            end
            trial = {src.rem, src.nq[W-1]};
            ge    = (trial >= {1'b0, src.ad});
            n_st[k]      = src;
            n_st[k].rem  = ge ? RW'(trial - {1'b0, src.ad}) : trial[RW-1:0];
            n_st[k].nq   = {src.nq[W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid     = r_v[W-1];
    assign o_data.quo  = r_st[W-1].nq;
    assign o_data.neg  = r_st[W-1].neg;
    assign o_data.side = r_st[W-1].side;

endmodule

// ----- rtl/stc_back.sv -----
// Back pipeline: pressure correction terms, saturation and the output register.
module stc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  stc_pkg::t_div_out i_data,
    input  stc_pkg::t_coeffs  i_coef,
    output logic              o_valid,
    output logic [26:0]       o_temperature_centi_c,
    output logic [31:0]       o_pressure_q24_8_pa,
    output logic [16:0]       o_humidity_q22_10,
    output logic [1:0]        o_status
);

    logic [6:1] r_v;

    logic [63:0] r1_p;
    logic [63:0] r2_p, r2_ll, r2_x2m;
    logic [31:0] r2_lh;
    logic [63:0] r3_p, r3_qq, r3_x2m;
    logic [63:0] r4_p, r4_x1m, r4_x2m;
    logic [63:0] r5_sum;
    stc_pkg::t_side r_side [1:5];

    logic [26:0] r_temp;
    logic [31:0] r_press;
    logic [16:0] r_hum;
    logic [1:0]  r_stat;

    logic [63:0] n2_q13;
    logic [31:0] n2_ql;
    logic [63:0] n6_pr;
    logic [31:0] n6_sat;

    always_comb begin
        n2_q13 = stc_pkg::asr64(r1_p, 13);
        n2_ql  = n2_q13[31:0];
        n6_pr  = stc_pkg::asr64(r5_sum, 8) + (stc_pkg::sx16_64(i_coef.p7) << 4);
        if (n6_pr[63]) begin
            n6_sat = 32'd0;
        end else if (|n6_pr[62:32]) begin
            n6_sat = '1;
        end else begin
            n6_sat = n6_pr[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p   <= i_data.neg ? 64'd0 - i_data.quo : i_data.quo;
            r2_p   <= r1_p;
            r2_ll  <= n2_ql * n2_ql;
            r2_lh  <= n2_ql * n2_q13[63:32];
            r2_x2m <= stc_pkg::mul64x16(r1_p, i_coef.p8, 1'b1);
            r3_p   <= r2_p;
            r3_qq  <= r2_ll + {r2_lh[30:0], 33'd0};
            r3_x2m <= r2_x2m;
            r4_p   <= r3_p;
            r4_x1m <= stc_pkg::mul64x16(r3_qq, i_coef.p9, 1'b1);
            r4_x2m <= r3_x2m;
            r5_sum <= r4_p + stc_pkg::asr64(r4_x1m, 25) + stc_pkg::asr64(r4_x2m, 19);
            r_side[1] <= i_data.side;
            for (int k = 2; k <= 5; k++) begin
                r_side[k] <= r_side[k-1];
            end
            if (r_side[5].sent) begin
                r_temp  <= '0;
                r_press <= '0;
                r_hum   <= '0;
                r_stat  <= stc_pkg::STAT_SENT;
            end else begin
                r_temp  <= r_side[5].temp;
                r_hum   <= r_side[5].hum;
                r_press <= r_side[5].divz ? 32'd0 : n6_sat;
                r_stat  <= r_side[5].divz ? stc_pkg::STAT_DIVZ : stc_pkg::STAT_OK;
            end
        end
    end

    assign o_valid               = r_v[6];
    assign o_temperature_centi_c = r_temp;
    assign o_pressure_q24_8_pa   = r_press;
    assign o_humidity_q22_10     = r_hum;
    assign o_status              = r_stat;

endmodule
